[rtl/kfcv_pkg.sv]
`timescale 1ns / 1ps
package kfcv_pkg;

   localparam int STATE_W = 32;
   localparam int COV_W = 48;
   localparam int GAIN_W = 56;
   localparam int WIDE_W = 62;
   localparam int DT_W = 24;
   localparam int VAR_W = 47;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 48;
   localparam int COV_FRAC_W = 40;
   localparam int DIV_W = COV_W + COV_FRAC_W;

   localparam logic [CSR_IDX_W-1:0] CSR_TIME_STEP = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NOISE_POS = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NOISE_CROSS = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_NOISE_VEL = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MEAS_VAR = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_START_POS = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_START_VEL = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_START_VAR = 3'd7;

   localparam logic [DT_W-1:0] TIME_STEP_RST = 24'd167772;
   localparam logic [VAR_W-1:0] NOISE_POS_RST = 47'd24739;
   localparam logic signed [COV_W-1:0] NOISE_CROSS_RST = 48'sd4947802;
   localparam logic [VAR_W-1:0] NOISE_VEL_RST = 47'd989560464;
   localparam logic [VAR_W-1:0] MEAS_VAR_RST = 47'd1099511627776;
   localparam logic signed [STATE_W-1:0] START_POS_RST = 32'sd0;
   localparam logic signed [STATE_W-1:0] START_VEL_RST = 32'sd655360;
   localparam logic [VAR_W-1:0] START_VAR_RST = 47'd1099511627776;

   function automatic logic ovf32(input logic signed [63:0] x);
      ovf32 = (x > 64'sd2147483647) || (x < -64'sd2147483648);
   endfunction

   function automatic logic signed [STATE_W-1:0] sat32(input logic signed [63:0] x);
      if (x > 64'sd2147483647) begin
         sat32 = 32'sh7fffffff;
      end else if (x < -64'sd2147483648) begin
         sat32 = 32'sh80000000;
      end else begin
         sat32 = x[STATE_W-1:0];
      end
   endfunction

   function automatic logic ovf48(input logic signed [63:0] x);
      ovf48 = (x > 64'sd140737488355327) || (x < -64'sd140737488355328);
   endfunction

   function automatic logic signed [COV_W-1:0] sat48(input logic signed [63:0] x);
      if (x > 64'sd140737488355327) begin
         sat48 = 48'sh7fffffffffff;
      end else if (x < -64'sd140737488355328) begin
         sat48 = 48'sh800000000000;
      end else begin
         sat48 = x[COV_W-1:0];
      end
   endfunction

endpackage

[rtl/kalman_filter_const_velocity.sv]
`timescale 1ns / 1ps
// each request runs three dt products, two gain divides and five gain products in turn,
// on the bit-serial shift-add multiplier and restoring divider they share
// one request at a time; next request taken while a response still waits
// last step holds while an earlier response beat is still waiting
// reset (synchronous, active high): configuration registers to defaults, state from start values
module kalman_filter_const_velocity (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [kfcv_pkg::STATE_W-1:0]   req_measurement,
   input  logic                                  req_restart,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [kfcv_pkg::STATE_W-1:0]   rsp_est_pos,
   output logic signed [kfcv_pkg::STATE_W-1:0]   rsp_est_vel,
   output logic                                  rsp_saturated,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [kfcv_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [kfcv_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import kfcv_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MLOAD = 3'd1;
   localparam logic [2:0] S_MRUN = 3'd2;
   localparam logic [2:0] S_MRND = 3'd3;
   localparam logic [2:0] S_DLOAD = 3'd4;
   localparam logic [2:0] S_DRUN = 3'd5;
   localparam logic [2:0] S_DRND = 3'd6;
   localparam logic [2:0] S_POST = 3'd7;

   localparam logic [3:0] OP_XP = 4'd0;
   localparam logic [3:0] OP_T = 4'd1;
   localparam logic [3:0] OP_P11 = 4'd2;
   localparam logic [3:0] OP_K1 = 4'd3;
   localparam logic [3:0] OP_K2 = 4'd4;
   localparam logic [3:0] OP_POS = 4'd5;
   localparam logic [3:0] OP_VEL = 4'd6;
   localparam logic [3:0] OP_CPP = 4'd7;
   localparam logic [3:0] OP_CPV = 4'd8;
   localparam logic [3:0] OP_CVV = 4'd9;

   logic [DT_W-1:0] time_step_ff, time_step_in;
   logic [VAR_W-1:0] noise_pos_ff, noise_pos_in;
   logic signed [COV_W-1:0] noise_cross_ff, noise_cross_in;
   logic [VAR_W-1:0] noise_vel_ff, noise_vel_in;
   logic [VAR_W-1:0] meas_var_ff, meas_var_in;
   logic signed [STATE_W-1:0] start_pos_ff, start_pos_in;
   logic signed [STATE_W-1:0] start_vel_ff, start_vel_in;
   logic [VAR_W-1:0] start_var_ff, start_var_in;

   logic [2:0] st_ff, st_in;
   logic [3:0] op_ff, op_in;
   logic [6:0] cnt_ff, cnt_in;
   logic [GAIN_W-1:0] ma_ff, ma_in;
   logic [63:0] mb_ff, mb_in;
   logic [119:0] acc_ff, acc_in;
   logic neg_ff, neg_in;
   logic [DIV_W-1:0] dq_ff, dq_in;
   logic [48:0] rem_ff, rem_in;
   logic [48:0] den_ff, den_in;
   logic signed [WIDE_W-1:0] res_ff, res_in;
   logic flag_ff, flag_in;

   logic signed [STATE_W-1:0] z_ff, z_in;
   logic signed [STATE_W-1:0] xp_ff, xp_in;
   logic signed [62:0] u_ff, u_in;
   logic signed [COV_W-1:0] p11p_ff, p11p_in, p12p_ff, p12p_in, p22p_ff, p22p_in;
   logic signed [GAIN_W-1:0] k1_ff, k1_in, k2_ff, k2_in;
   logic signed [STATE_W-1:0] pos_ff, pos_in, vel_ff, vel_in;
   logic signed [COV_W-1:0] cpp_ff, cpp_in, cpv_ff, cpv_in, cvv_ff, cvv_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic signed [STATE_W-1:0] rsp_pos_ff, rsp_pos_in, rsp_vel_ff, rsp_vel_in;
   logic rsp_sat_ff, rsp_sat_in;

   logic dt_op;
   logic signed [63:0] b_sel;
   logic signed [63:0] k_sel;
   logic [119:0] rnd_sum;
   logic [119:0] rnd_shift;
   logic [119:0] mlim;
   logic [61:0] mmag;
   logic [49:0] rem2;
   logic div_ge;
   logic signed [48:0] s_val;
   logic signed [COV_W-1:0] num_sel;
   logic [88:0] q_rnd;
   logic [88:0] dlim;
   logic [55:0] dmag;
   logic signed [63:0] post_sum;
   logic signed [63:0] innov;

   assign req_ready = (st_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_est_pos = rsp_pos_ff;
   assign rsp_est_vel = rsp_vel_ff;
   assign rsp_saturated = rsp_sat_ff;

   assign dt_op = (op_ff == OP_XP) || (op_ff == OP_T) || (op_ff == OP_P11);
   assign innov = 64'(z_ff) - 64'(xp_ff);
   assign k_sel = ((op_ff == OP_VEL) || (op_ff == OP_CVV)) ? 64'(k2_ff) : 64'(k1_ff);
   assign s_val = 49'(p11p_ff) + 49'(signed'({1'b0, meas_var_ff}));
   assign num_sel = (op_ff == OP_K1) ? p11p_ff : p12p_ff;

   always_comb begin
      case (op_ff)
         OP_XP: b_sel = 64'(vel_ff);
         OP_T: b_sel = 64'(cvv_ff);
         OP_P11: b_sel = 64'(cpv_ff) + 64'(u_ff);
         OP_POS: b_sel = innov;
         OP_VEL: b_sel = innov;
         OP_CPP: b_sel = 64'(p11p_ff);
         OP_CPV: b_sel = 64'(p12p_ff);
         OP_CVV: b_sel = 64'(p12p_ff);
         default: b_sel = 64'sd0;
      endcase
   end

   always_comb begin
      rnd_sum = acc_ff + (dt_op ? (120'd1 << (DT_W - 1)) : (120'd1 << (COV_FRAC_W - 1)));
      rnd_shift = dt_op ? (rnd_sum >> DT_W) : (rnd_sum >> COV_FRAC_W);
      mlim = (120'd1 << (WIDE_W - 1)) - 120'(!neg_ff);
      mmag = (rnd_shift > mlim) ? mlim[61:0] : rnd_shift[61:0];
      rem2 = {rem_ff, dq_ff[DIV_W-1]};
      div_ge = rem2 >= {1'b0, den_ff};
      q_rnd = 89'(dq_ff) + 89'(({rem_ff, 1'b0} >= {1'b0, den_ff}) ? 1 : 0);
      dlim = (89'd1 << (GAIN_W - 1)) - 89'(!neg_ff);
      dmag = (q_rnd > dlim) ? dlim[55:0] : q_rnd[55:0];
      case (op_ff)
         OP_XP: post_sum = 64'(pos_ff) + 64'(res_ff);
         OP_T: post_sum = 64'(cpv_ff) + 64'(res_ff) + 64'(noise_cross_ff);
         OP_P11: post_sum = 64'(cpp_ff) + 64'(res_ff) + 64'({17'd0, noise_pos_ff});
         OP_POS: post_sum = 64'(xp_ff) + 64'(res_ff);
         OP_VEL: post_sum = 64'(vel_ff) + 64'(res_ff);
         OP_CPP: post_sum = 64'(p11p_ff) - 64'(res_ff);
         OP_CPV: post_sum = 64'(p12p_ff) - 64'(res_ff);
         OP_CVV: post_sum = 64'(p22p_ff) - 64'(res_ff);
         default: post_sum = 64'sd0;
      endcase
   end

   always_comb begin
      time_step_in = time_step_ff;
      noise_pos_in = noise_pos_ff;
      noise_cross_in = noise_cross_ff;
      noise_vel_in = noise_vel_ff;
      meas_var_in = meas_var_ff;
      start_pos_in = start_pos_ff;
      start_vel_in = start_vel_ff;
      start_var_in = start_var_ff;
      st_in = st_ff;
      op_in = op_ff;
      cnt_in = cnt_ff;
      ma_in = ma_ff;
      mb_in = mb_ff;
      acc_in = acc_ff;
      neg_in = neg_ff;
      dq_in = dq_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      res_in = res_ff;
      flag_in = flag_ff;
      z_in = z_ff;
      xp_in = xp_ff;
      u_in = u_ff;
      p11p_in = p11p_ff;
      p12p_in = p12p_ff;
      p22p_in = p22p_ff;
      k1_in = k1_ff;
      k2_in = k2_ff;
      pos_in = pos_ff;
      vel_in = vel_ff;
      cpp_in = cpp_ff;
      cpv_in = cpv_ff;
      cvv_in = cvv_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_pos_in = rsp_pos_ff;
      rsp_vel_in = rsp_vel_ff;
      rsp_sat_in = rsp_sat_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_valid) begin
         case (csr_index)
            CSR_TIME_STEP: time_step_in = csr_wdata[DT_W-1:0];
            CSR_NOISE_POS: noise_pos_in = csr_wdata[VAR_W-1:0];
            CSR_NOISE_CROSS: noise_cross_in = signed'(csr_wdata[COV_W-1:0]);
            CSR_NOISE_VEL: noise_vel_in = csr_wdata[VAR_W-1:0];
            CSR_MEAS_VAR: meas_var_in = csr_wdata[VAR_W-1:0];
            CSR_START_POS: start_pos_in = signed'(csr_wdata[STATE_W-1:0]);
            CSR_START_VEL: start_vel_in = signed'(csr_wdata[STATE_W-1:0]);
            CSR_START_VAR: start_var_in = csr_wdata[VAR_W-1:0];
            default: time_step_in = time_step_ff;
         endcase
      end

      case (st_ff)
         S_IDLE: begin
            if (req_valid) begin
               z_in = req_measurement;
               flag_in = 1'b0;
               op_in = OP_XP;
               st_in = S_MLOAD;
               if (req_restart) begin
                  pos_in = start_pos_ff;
                  vel_in = start_vel_ff;
                  cpp_in = signed'({1'b0, start_var_ff});
                  cpv_in = '0;
                  cvv_in = signed'({1'b0, start_var_ff});
               end
            end
         end
         S_MLOAD: begin
            mb_in = b_sel[63] ? 64'(-b_sel) : 64'(b_sel);
            acc_in = '0;
            if (dt_op) begin
               ma_in = {time_step_ff, 32'd0};
               neg_in = b_sel[63];
               cnt_in = 7'(DT_W);
            end else begin
               ma_in = k_sel[63] ? 56'(-k_sel) : k_sel[55:0];
               neg_in = k_sel[63] ^ b_sel[63];
               cnt_in = 7'(GAIN_W);
            end
            st_in = S_MRUN;
         end
         S_MRUN: begin
            acc_in = (acc_ff << 1) + (ma_ff[GAIN_W-1] ? 120'(mb_ff) : 120'd0);
            ma_in = ma_ff << 1;
            cnt_in = cnt_ff - 7'd1;
            if (cnt_ff == 7'd1) begin
               st_in = S_MRND;
            end
         end
         S_MRND: begin
            if (rnd_shift > mlim) begin
               flag_in = 1'b1;
            end
            res_in = signed'(neg_ff ? (~mmag + 62'd1) : mmag);
            st_in = S_POST;
         end
         S_DLOAD: begin
            neg_in = num_sel[COV_W-1] ^ s_val[48];
            den_in = s_val[48] ? 49'(-s_val) : 49'(s_val);
            dq_in = {(num_sel[COV_W-1] ? 48'(-num_sel) : 48'(num_sel)), {COV_FRAC_W{1'b0}}};
            rem_in = '0;
            cnt_in = 7'(DIV_W);
            if (s_val == 49'sd0) begin
               res_in = '0;
               st_in = S_POST;
            end else begin
               st_in = S_DRUN;
            end
         end
         S_DRUN: begin
            rem_in = div_ge ? 49'(rem2 - {1'b0, den_ff}) : rem2[48:0];
            dq_in = {dq_ff[DIV_W-2:0], div_ge};
            cnt_in = cnt_ff - 7'd1;
            if (cnt_ff == 7'd1) begin
               st_in = S_DRND;
            end
         end
         S_DRND: begin
            if (q_rnd > dlim) begin
               flag_in = 1'b1;
            end
            res_in = 62'(signed'(neg_ff ? (~dmag + 56'd1) : dmag));
            st_in = S_POST;
         end
         S_POST: begin
            op_in = op_ff + 4'd1;
            st_in = ((op_ff == OP_T) || (op_ff == OP_P11)) ? S_MLOAD
                  : ((op_ff == OP_P11 + 4'd0) ? S_DLOAD : S_MLOAD);
            if (op_ff == OP_P11 || op_ff == OP_K1) begin
               st_in = S_DLOAD;
            end
            case (op_ff)
               OP_XP: begin
                  xp_in = sat32(post_sum);
                  flag_in = flag_ff | ovf32(post_sum);
               end
               OP_T: begin
                  u_in = 63'(cpv_ff) + 63'(res_ff);
                  p12p_in = sat48(post_sum);
                  p22p_in = sat48(64'(cvv_ff) + 64'({17'd0, noise_vel_ff}));
                  flag_in = flag_ff | ovf48(post_sum)
                          | ovf48(64'(cvv_ff) + 64'({17'd0, noise_vel_ff}));
               end
               OP_P11: begin
                  p11p_in = sat48(post_sum);
                  flag_in = flag_ff | ovf48(post_sum);
               end
               OP_K1: k1_in = res_ff[GAIN_W-1:0];
               OP_K2: k2_in = res_ff[GAIN_W-1:0];
               OP_POS: begin
                  pos_in = sat32(post_sum);
                  flag_in = flag_ff | ovf32(post_sum);
               end
               OP_VEL: begin
                  vel_in = sat32(post_sum);
                  flag_in = flag_ff | ovf32(post_sum);
               end
               OP_CPP: begin
                  cpp_in = sat48(post_sum);
                  flag_in = flag_ff | ovf48(post_sum);
               end
               OP_CPV: begin
                  cpv_in = sat48(post_sum);
                  flag_in = flag_ff | ovf48(post_sum);
               end
               OP_CVV: begin
                  if (rsp_valid_ff && !rsp_ready) begin
                     op_in = op_ff;
                     st_in = S_POST;
                  end else begin
                     cvv_in = sat48(post_sum);
                     flag_in = flag_ff | ovf48(post_sum);
                     rsp_valid_in = 1'b1;
                     rsp_pos_in = pos_ff;
                     rsp_vel_in = vel_ff;
                     rsp_sat_in = flag_ff | ovf48(post_sum);
                     st_in = S_IDLE;
                  end
               end
               default: st_in = S_IDLE;
            endcase
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_step_ff <= TIME_STEP_RST;
         noise_pos_ff <= NOISE_POS_RST;
         noise_cross_ff <= NOISE_CROSS_RST;
         noise_vel_ff <= NOISE_VEL_RST;
         meas_var_ff <= MEAS_VAR_RST;
         start_pos_ff <= START_POS_RST;
         start_vel_ff <= START_VEL_RST;
         start_var_ff <= START_VAR_RST;
         st_ff <= S_IDLE;
         op_ff <= OP_XP;
         cnt_ff <= '0;
         flag_ff <= 1'b0;
         pos_ff <= START_POS_RST;
         vel_ff <= START_VEL_RST;
         cpp_ff <= signed'({1'b0, START_VAR_RST});
         cpv_ff <= '0;
         cvv_ff <= signed'({1'b0, START_VAR_RST});
         rsp_valid_ff <= 1'b0;
      end else begin
         time_step_ff <= time_step_in;
         noise_pos_ff <= noise_pos_in;
         noise_cross_ff <= noise_cross_in;
         noise_vel_ff <= noise_vel_in;
         meas_var_ff <= meas_var_in;
         start_pos_ff <= start_pos_in;
         start_vel_ff <= start_vel_in;
         start_var_ff <= start_var_in;
         st_ff <= st_in;
         op_ff <= op_in;
         cnt_ff <= cnt_in;
         flag_ff <= flag_in;
         pos_ff <= pos_in;
         vel_ff <= vel_in;
         cpp_ff <= cpp_in;
         cpv_ff <= cpv_in;
         cvv_ff <= cvv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ma_ff <= ma_in;
      mb_ff <= mb_in;
      acc_ff <= acc_in;
      neg_ff <= neg_in;
      dq_ff <= dq_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      res_ff <= res_in;
      z_ff <= z_in;
      xp_ff <= xp_in;
      u_ff <= u_in;
      p11p_ff <= p11p_in;
      p12p_ff <= p12p_in;
      p22p_ff <= p22p_in;
      k1_ff <= k1_in;
      k2_ff <= k2_in;
      rsp_pos_ff <= rsp_pos_in;
      rsp_vel_ff <= rsp_vel_in;
      rsp_sat_ff <= rsp_sat_in;
   end

endmodule
